// ===== rtl/skeleton_branch_contact_3d_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the skeleton branch contact unit
// Shared helpers for concurrent checks; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SKELETON_BRANCH_CONTACT_3D_UNIT_DEFINES_SVH
`define SKELETON_BRANCH_CONTACT_3D_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SKBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SKBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/skbc_pkg.sv =====
// ----------------------------------------------------------------------------
// skbc_pkg
// Types, codes and constants shared by the skeleton branch contact unit.
// ----------------------------------------------------------------------------
package skbc_pkg;

    // Field widths of the item, result and configuration words.
    localparam int COORD_W         = 6;
    localparam int DIM_W           = 7;
    localparam int LABEL_W         = 8;
    localparam int REG_IDX_W       = 2;
    localparam int MAX_DIM_DEFAULT = 64;

    // Dimension registers come out of reset at the full volume.
    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    // Neighborhood offsets run 0..2 along each axis (3 x 3 x 3 voxels).
    localparam logic [1:0] OFFSET_LAST   = 2'd2;
    localparam logic [1:0] OFFSET_CENTER = 2'd1;

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [REG_IDX_W-1:0]
    {
        REG_COLS   = 2'd0,
        REG_ROWS   = 2'd1,
        REG_SLICES = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic capture;
        logic write_en;
        logic scan_step;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic in_inside;
        logic scan_last;
    } ctrl_status_t;

endpackage

// ===== rtl/skbc_item_if.sv =====
// ----------------------------------------------------------------------------
// skbc_item_if
// Input channel: one write or query word per handshake.
// ----------------------------------------------------------------------------
interface skbc_item_if
    import skbc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               command;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic               initial_bit;
    logic               reduced_bit;
    logic [LABEL_W-1:0] component_label;

    modport source
    (
        output valid, command, coord_x, coord_y, coord_z,
        output initial_bit, reduced_bit, component_label,
        input  ready
    );

    modport sink
    (
        input  valid, command, coord_x, coord_y, coord_z,
        input  initial_bit, reduced_bit, component_label,
        output ready
    );
endinterface

// ===== rtl/skbc_result_if.sv =====
// ----------------------------------------------------------------------------
// skbc_result_if
// Result channel: one word per query.
// ----------------------------------------------------------------------------
interface skbc_result_if
    import skbc_pkg::*;
();
    logic valid;
    logic ready;
    logic touching;
    logic branch_out;

    modport source
    (
        output valid, touching, branch_out,
        input  ready
    );

    modport sink
    (
        input  valid, touching, branch_out,
        output ready
    );
endinterface

// ===== rtl/skbc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// skbc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface skbc_cfg_if
    import skbc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source
    (
        output valid, index, data,
        input  ready
    );

    modport sink
    (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/skbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// skbc_ctrl
// Controller: accepts words, sequences the neighborhood scan of a query and
// owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module skbc_ctrl
    import skbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  logic         item_command,
    output logic         item_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // State and result valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_command == CMD_QUERY)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = status.in_inside ? ST_SCAN : ST_DONE;
                    end
                    else
                    begin
                        cmd.write_en = status.in_inside;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The last read word is folded into the accumulators here.
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.load_out | (out_valid_reg & ~out_ready);
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/skbc_datapath.sv =====
// ----------------------------------------------------------------------------
// skbc_datapath
// Voxel memory, dimension registers, neighbor address generation and the
// touching accumulators with the result register.
// ----------------------------------------------------------------------------
module skbc_datapath
    import skbc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [COORD_W-1:0]   coord_x,
    input  logic [COORD_W-1:0]   coord_y,
    input  logic [COORD_W-1:0]   coord_z,
    input  logic                 initial_bit,
    input  logic                 reduced_bit,
    input  logic [LABEL_W-1:0]   component_label,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  ctrl_cmd_t            cmd,
    output ctrl_status_t         status,
    output logic                 touching,
    output logic                 branch_out
);

    localparam int AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CMPW   = ($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W;
    localparam int ADDR_W = 3 * AW;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam logic [CMPW-1:0] MAX_DIM_C = CMPW'(MAX_DIM);
    localparam logic [CMPW-1:0] ONE_C     = CMPW'(1);

    logic [DIM_W-1:0]   cols_reg;
    logic [DIM_W-1:0]   rows_reg;
    logic [DIM_W-1:0]   slices_reg;
    logic [CMPW-1:0]    nc;
    logic [CMPW-1:0]    nr;
    logic [CMPW-1:0]    ns;

    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [COORD_W-1:0] z_reg;
    logic [1:0]         dx_reg;
    logic [1:0]         dy_reg;
    logic [1:0]         dz_reg;
    logic [1:0]         dx_next;
    logic [1:0]         dy_next;
    logic [1:0]         dz_next;

    logic [CMPW-1:0]    wx;
    logic [CMPW-1:0]    wy;
    logic [CMPW-1:0]    wz;
    logic [CMPW-1:0]    nx;
    logic [CMPW-1:0]    ny;
    logic [CMPW-1:0]    nz;
    logic               nbr_inside;
    logic               at_center;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    // Bit 1 is the labeled flag, bit 0 the branch flag.
    logic [1:0]         mem [DEPTH];
    logic [1:0]         rd_data_reg;
    logic               pend_reg;
    logic               pend_center_reg;
    logic               labeled_reg;
    logic               branch_any_reg;
    logic               center_branch_reg;
    logic               touching_reg;
    logic               branch_out_reg;

    // Dimension registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg   <= DIM_RESET;
            rows_reg   <= DIM_RESET;
            slices_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLS:   cols_reg   <= cfg_data;
                REG_ROWS:   rows_reg   <= cfg_data;
                REG_SLICES: slices_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Dimensions in use, capped at the size of the memory.
    assign nc = (CMPW'(cols_reg) > MAX_DIM_C) ? MAX_DIM_C : CMPW'(cols_reg);
    assign nr = (CMPW'(rows_reg) > MAX_DIM_C) ? MAX_DIM_C : CMPW'(rows_reg);
    assign ns = (CMPW'(slices_reg) > MAX_DIM_C) ? MAX_DIM_C : CMPW'(slices_reg);

    // Incoming word: bounds check and write address.
    assign wx = CMPW'(coord_x);
    assign wy = CMPW'(coord_y);
    assign wz = CMPW'(coord_z);
    assign status.in_inside = (wx < nc) && (wy < nr) && (wz < ns);
    assign wr_addr = {wz[AW-1:0], wy[AW-1:0], wx[AW-1:0]};

    // Neighbor position: captured voxel plus offset minus one on each axis.
    assign nx = CMPW'(x_reg) + CMPW'(dx_reg) - ONE_C;
    assign ny = CMPW'(y_reg) + CMPW'(dy_reg) - ONE_C;
    assign nz = CMPW'(z_reg) + CMPW'(dz_reg) - ONE_C;
    assign nbr_inside = ((x_reg != '0) || (dx_reg != '0)) && (nx < nc)
                     && ((y_reg != '0) || (dy_reg != '0)) && (ny < nr)
                     && ((z_reg != '0) || (dz_reg != '0)) && (nz < ns);
    assign at_center = (dx_reg == OFFSET_CENTER) && (dy_reg == OFFSET_CENTER)
                    && (dz_reg == OFFSET_CENTER);
    assign rd_addr = {nz[AW-1:0], ny[AW-1:0], nx[AW-1:0]};

    // Offset counters: z runs fastest, then x, then y.
    always_comb
    begin
        dz_next = dz_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        if (cmd.capture)
        begin
            dz_next = '0;
            dx_next = '0;
            dy_next = '0;
        end
        else if (cmd.scan_step)
        begin
            if (dz_reg != OFFSET_LAST)
            begin
                dz_next = dz_reg + 2'd1;
            end
            else
            begin
                dz_next = '0;
                if (dx_reg != OFFSET_LAST)
                begin
                    dx_next = dx_reg + 2'd1;
                end
                else
                begin
                    dx_next = '0;
                    dy_next = dy_reg + 2'd1;
                end
            end
        end
    end

    assign status.scan_last = (dz_reg == OFFSET_LAST) && (dx_reg == OFFSET_LAST)
                           && (dy_reg == OFFSET_LAST);

    // Captured query position.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg <= coord_x;
            y_reg <= coord_y;
            z_reg <= coord_z;
        end
    end

    // Voxel memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.write_en)
        begin
            mem[wr_addr] <= {(component_label != '0), (initial_bit & ~reduced_bit)};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Scan control and accumulators, which work on the registered read word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg            <= '0;
            dy_reg            <= '0;
            dz_reg            <= '0;
            pend_reg          <= 1'b0;
            pend_center_reg   <= 1'b0;
            labeled_reg       <= 1'b0;
            branch_any_reg    <= 1'b0;
            center_branch_reg <= 1'b0;
        end
        else
        begin
            dx_reg          <= dx_next;
            dy_reg          <= dy_next;
            dz_reg          <= dz_next;
            pend_reg        <= cmd.scan_step & nbr_inside;
            pend_center_reg <= cmd.scan_step & at_center;
            if (cmd.capture)
            begin
                labeled_reg       <= 1'b0;
                branch_any_reg    <= 1'b0;
                center_branch_reg <= 1'b0;
            end
            else
            begin
                if (pend_reg && rd_data_reg[0])
                begin
                    branch_any_reg <= 1'b1;
                end
                if (pend_center_reg)
                begin
                    labeled_reg       <= rd_data_reg[1];
                    center_branch_reg <= rd_data_reg[0];
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            touching_reg   <= labeled_reg & branch_any_reg;
            branch_out_reg <= (labeled_reg & branch_any_reg) | center_branch_reg;
        end
    end

    assign touching   = touching_reg;
    assign branch_out = branch_out_reg;

endmodule

// ===== rtl/skeleton_branch_contact_3d_unit.sv =====
// Writes take effect in their accept cycle. A query inside the volume reads its
// 27 neighbors in the scan state, drains, and loads its word in the done state;
// a query outside it goes straight to done. Throughput: one write per cycle while
// idle; a query holds off new words until loaded (single voxel memory read port).
// Reset: control and dimension registers reset (dimensions to 64); the voxel
// memory is not cleared and holds unknown data until written.
// ----------------------------------------------------------------------------
// skeleton_branch_contact_3d_unit
// Stores branch and labeled bits per voxel and answers, per query, whether a
// labeled voxel has a branch voxel in its 3x3x3 neighborhood.
// ----------------------------------------------------------------------------
module skeleton_branch_contact_3d_unit
    import skbc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    skbc_item_if.sink     item,
    skbc_result_if.source result,
    skbc_cfg_if.sink      cfg
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // Configuration writes are taken in any cycle.
    assign cfg.ready = 1'b1;

    // Controller.
    skbc_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_command (item.command),
        .item_ready   (item.ready),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    // Datapath.
    skbc_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .coord_x         (item.coord_x),
        .coord_y         (item.coord_y),
        .coord_z         (item.coord_z),
        .initial_bit     (item.initial_bit),
        .reduced_bit     (item.reduced_bit),
        .component_label (item.component_label),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .cmd             (cmd),
        .status          (status),
        .touching        (result.touching),
        .branch_out      (result.branch_out)
    );

endmodule

// ===== rtl/skbc_checker.sv =====
// ----------------------------------------------------------------------------
// skbc_checker
// Port-level checks on the skeleton branch contact unit, bound to the top.
// ----------------------------------------------------------------------------
`include "skeleton_branch_contact_3d_unit_defines.svh"

module skbc_checker
(
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_ready,
    input logic item_command,
    input logic result_valid,
    input logic result_ready,
    input logic result_touching,
    input logic result_branch_out
);

    // A stalled result word stays offered.
    `SKBC_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid, "result word dropped while stalled")

    // A stalled result word keeps its value.
    `SKBC_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result_touching) && $stable(result_branch_out), "result word changed while stalled")

    // A touching voxel always reports its branch bit set.
    `SKBC_ASSERT_NOW(a_touch_implies_branch, result_valid && result_touching, result_branch_out, "touching without branch bit")

    // A write never produces a result word.
    `SKBC_ASSERT_NEXT(a_write_silent, item_valid && item_ready && !item_command && !result_valid, !result_valid, "result word after a write")

    // After a query is taken the input is not ready in the next cycle.
    `SKBC_ASSERT_NEXT(a_query_busy, item_valid && item_ready && item_command, !item_ready, "input taken while a query is in progress")

endmodule

bind skeleton_branch_contact_3d_unit skbc_checker u_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .item_command      (item.command),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_touching   (result.touching),
    .result_branch_out (result.branch_out)
);

// ===== tb/skeleton_branch_contact_3d_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skeleton_branch_contact_3d_unit_test
// Drives write and query words into the voxel contact unit and checks every
// result word against its table row or a model of the branch and labeled stores.
// A table of directed words at the volume corners runs first. Random phases
// follow, each with its own volume size. Both channels idle at random.
// ----------------------------------------------------------------------------
module skeleton_branch_contact_3d_unit_test;
    import skbc_pkg::*;

    localparam int VOL_DIM    = MAX_DIM_DEFAULT;
    localparam int VOXELS     = VOL_DIM * VOL_DIM * VOL_DIM;
    localparam int NUM_ROWS   = 24;
    localparam int MAX_SHOWN  = 10;

    // One expected result word.
    typedef struct packed
    {
        logic touching;
        logic branch_out;
    } contact_t;

    // One row of the directed table; checked rows carry their result.
    typedef struct packed
    {
        cmd_t               command;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               initial_bit;
        logic               reduced_bit;
        logic [LABEL_W-1:0] label;
        logic               checked;
        logic               touching;
        logic               branch_out;
    } stim_row_t;

    logic clk;
    logic rst_n;

    skbc_item_if   item_bus ();
    skbc_result_if result_bus ();
    skbc_cfg_if    cfg_bus ();

    skeleton_branch_contact_3d_unit #(
        .MAX_DIM (VOL_DIM)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // Local copy of the voxel stores and of the dimensions in use.
    bit             branch_mem  [VOXELS];
    bit             labeled_mem [VOXELS];
    bit             written_mem [VOXELS];
    int             dim_eff [3];
    int             win_lo [3];
    int             win_span [3];
    int             branch_pct;

    contact_t       pending_contacts [$];
    contact_t       expected_contact;
    int             mismatches;
    int             words_sent;
    int             stall_left;
    bit             no_gaps;
    bit             sink_eager;

    // Corner cubes at both ends of the full volume, then queries whose result
    // follows directly from what was just written.
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{CMD_WRITE, 6'd0,  6'd0,  6'd0,  1'b0, 1'b1, 8'd255, 1'b0, 1'b0, 1'b0},
        '{CMD_WRITE, 6'd1,  6'd0,  6'd0,  1'b1, 1'b1, 8'd1,   1'b0, 1'b0, 1'b0},
        '{CMD_WRITE, 6'd0,  6'd1,  6'd0,  1'b0, 1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
        '{CMD_WRITE, 6'd0,  6'd0,  6'd1,  1'b0, 1'b0, 8'd42,  1'b0, 1'b0, 1'b0},
        '{CMD_WRITE, 6'd1,  6'd1,  6'd0,  1'b1, 1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
        '{CMD_WRITE, 6'd1,  6'd0,  6'd1,  1'b0, 1'b0, 8'd0,   1'b0, 1'b0, 1'b0},
        '{CMD_WRITE, 6'd0,  6'd1,  6'd1,  1'b0, 1'b1, 8'd200, 1'b0, 1'b0, 1'b0},
        '{CMD_WRITE, 6'd1,  6'd1,  6'd1,  1'b1, 1'b0, 8'd0,   1'b0, 1'b0, 1'b0},
        // Labeled corner next to a branch voxel.
        '{CMD_QUERY, 6'd0,  6'd0,  6'd0,  1'b0, 1'b0, 8'd0,   1'b1, 1'b1, 1'b1},
        // Clear that branch; query payload bits are ignored.
        '{CMD_WRITE, 6'd1,  6'd1,  6'd1,  1'b1, 1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
        '{CMD_QUERY, 6'd0,  6'd0,  6'd0,  1'b1, 1'b1, 8'd255, 1'b1, 1'b0, 1'b0},
        // The center voxel itself is a labeled branch.
        '{CMD_WRITE, 6'd0,  6'd0,  6'd0,  1'b1, 1'b0, 8'd1,   1'b0, 1'b0, 1'b0},
        '{CMD_QUERY, 6'd0,  6'd0,  6'd0,  1'b0, 1'b1, 8'd128, 1'b1, 1'b1, 1'b1},
        // Unlabeled branch: no contact, stored bit passes through.
        '{CMD_WRITE, 6'd0,  6'd0,  6'd0,  1'b1, 1'b0, 8'd0,   1'b0, 1'b0, 1'b0},
        '{CMD_QUERY, 6'd0,  6'd0,  6'd0,  1'b1, 1'b0, 8'd85,  1'b1, 1'b0, 1'b1},
        // Far corner of the volume.
        '{CMD_WRITE, 6'd62, 6'd62, 6'd62, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0, 1'b0},
        '{CMD_WRITE, 6'd63, 6'd62, 6'd62, 1'b0, 1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
        '{CMD_WRITE, 6'd62, 6'd63, 6'd62, 1'b1, 1'b1, 8'd3,   1'b0, 1'b0, 1'b0},
        '{CMD_WRITE, 6'd62, 6'd62, 6'd63, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0, 1'b0},
        '{CMD_WRITE, 6'd63, 6'd63, 6'd62, 1'b0, 1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
        '{CMD_WRITE, 6'd63, 6'd62, 6'd63, 1'b0, 1'b0, 8'd170, 1'b0, 1'b0, 1'b0},
        '{CMD_WRITE, 6'd62, 6'd63, 6'd63, 1'b1, 1'b1, 8'd7,   1'b0, 1'b0, 1'b0},
        '{CMD_WRITE, 6'd63, 6'd63, 6'd63, 1'b0, 1'b0, 8'd128, 1'b0, 1'b0, 1'b0},
        '{CMD_QUERY, 6'd63, 6'd63, 6'd63, 1'b0, 1'b0, 8'd0,   1'b1, 1'b1, 1'b1}
    };

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #20_000_000;
        $display("skeleton_branch_contact_3d_unit_test: errors");
        $finish;
    end

    function automatic int voxel_addr(input int x, input int y, input int z);
        return (z * VOL_DIM + y) * VOL_DIM + x;
    endfunction

    function automatic bit in_volume(input int x, input int y, input int z);
        return x >= 0 && y >= 0 && z >= 0 &&
               x < dim_eff[0] && y < dim_eff[1] && z < dim_eff[2];
    endfunction

    // Contact and updated branch bit for one queried voxel.
    function automatic contact_t predict_contact(input int x, input int y, input int z);
        contact_t c;
        int       addr;
        c = '0;
        if (in_volume(x, y, z))
        begin
            addr = voxel_addr(x, y, z);
            if (labeled_mem[addr])
            begin
                for (int dz = -1; dz <= 1; dz++)
                    for (int dy = -1; dy <= 1; dy++)
                        for (int dx = -1; dx <= 1; dx++)
                            if (in_volume(x + dx, y + dy, z + dz) &&
                                branch_mem[voxel_addr(x + dx, y + dy, z + dz)])
                                c.touching = 1'b1;
            end
            c.branch_out = c.touching | branch_mem[addr];
        end
        return c;
    endfunction

    // Idle cycles before the next word: mostly none or short, a few long.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(99, 0);
        if (no_gaps || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Present one word, wait for its handshake and update the local stores.
    task automatic send_word(input cmd_t command, input int x, input int y, input int z,
                             input logic init_b, input logic red_b,
                             input logic [LABEL_W-1:0] label,
                             input logic checked, input contact_t typed_contact);
        int gap;
        int addr;
        gap = draw_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            item_bus.valid = 1'b0;
            repeat (gap) @(posedge clk);
        end
        @(negedge clk);
        item_bus.command         = command;
        item_bus.coord_x         = COORD_W'(x);
        item_bus.coord_y         = COORD_W'(y);
        item_bus.coord_z         = COORD_W'(z);
        item_bus.initial_bit     = init_b;
        item_bus.reduced_bit     = red_b;
        item_bus.component_label = label;
        item_bus.valid           = 1'b1;
        do
            @(posedge clk);
        while (item_bus.ready !== 1'b1);

        if (command == CMD_WRITE)
        begin
            if (in_volume(x, y, z))
            begin
                addr = voxel_addr(x, y, z);
                branch_mem[addr]  = init_b & ~red_b;
                labeled_mem[addr] = |label;
                written_mem[addr] = 1'b1;
            end
        end
        else
        begin
            pending_contacts.push_back(checked ? typed_contact : predict_contact(x, y, z));
        end
        words_sent++;
    endtask

    // Write one voxel with random content at the phase's branch density.
    task automatic write_voxel(input int x, input int y, input int z);
        logic init_b;
        logic red_b;
        logic [LABEL_W-1:0] label;
        int   k;
        if ($urandom_range(99, 0) < branch_pct)
        begin
            init_b = 1'b1;
            red_b  = 1'b0;
        end
        else
        begin
            k      = $urandom_range(2, 0);
            init_b = (k == 2);
            red_b  = (k != 0);
        end
        k = $urandom_range(99, 0);
        if (k < 30)
            label = '0;
        else if (k < 40)
            label = '1;
        else
            label = LABEL_W'($urandom_range(254, 1));
        send_word(CMD_WRITE, x, y, z, init_b, red_b, label, 1'b0, '0);
    endtask

    // Write every unwritten voxel around a position, then query it.
    task automatic probe_voxel(input int x, input int y, input int z);
        for (int dz = -1; dz <= 1; dz++)
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++)
                    if (in_volume(x + dx, y + dy, z + dz) &&
                        !written_mem[voxel_addr(x + dx, y + dy, z + dz)])
                        write_voxel(x + dx, y + dy, z + dz);
        send_word(CMD_QUERY, x, y, z, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                  LABEL_W'($urandom_range(255, 0)), 1'b0, '0);
    endtask

    // Hold the input channel and let every expected word come back.
    task automatic wait_drained();
        @(negedge clk);
        item_bus.valid = 1'b0;
        while (pending_contacts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t index, input logic [DIM_W-1:0] value);
        @(negedge clk);
        cfg_bus.index = index;
        cfg_bus.data  = value;
        cfg_bus.valid = 1'b1;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        dim_eff[index] = (value > VOL_DIM) ? VOL_DIM : int'(value);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // One random phase: resize the volume while idle, then mostly probes of a
    // small window plus rewrites, out-of-volume words and scattered probes.
    task automatic run_phase(input int cols, input int rows, input int slices,
                             input int budget);
        int start;
        int r;
        int axis;
        int c [3];
        bit has_inside;
        bit has_outside;
        wait_drained();
        repeat (4) @(posedge clk);
        write_reg(REG_COLS, DIM_W'(cols));
        write_reg(REG_ROWS, DIM_W'(rows));
        write_reg(REG_SLICES, DIM_W'(slices));

        for (int a = 0; a < 3; a++)
        begin
            win_span[a] = (dim_eff[a] < 4) ? dim_eff[a] : 4;
            case ($urandom_range(2, 0))
                0: win_lo[a] = 0;
                1: win_lo[a] = dim_eff[a] - win_span[a];
                default: win_lo[a] = $urandom_range(dim_eff[a] - win_span[a], 0);
            endcase
        end
        case ($urandom_range(2, 0))
            0: branch_pct = 5;
            1: branch_pct = 30;
            default: branch_pct = 70;
        endcase
        no_gaps     = ($urandom_range(3, 0) == 0);
        sink_eager  = ($urandom_range(3, 0) == 0);
        has_inside  = dim_eff[0] > 0 && dim_eff[1] > 0 && dim_eff[2] > 0;
        has_outside = dim_eff[0] < VOL_DIM || dim_eff[1] < VOL_DIM || dim_eff[2] < VOL_DIM;

        start = words_sent;
        while (words_sent - start < budget)
        begin
            r = $urandom_range(99, 0);
            for (int a = 0; a < 3; a++)
                c[a] = has_inside ? win_lo[a] + $urandom_range(win_span[a] - 1, 0) : 0;
            if (r < 3)
                wait_drained();
            else if (has_inside && r < 63)
                probe_voxel(c[0], c[1], c[2]);
            else if (has_inside && r < 80)
                write_voxel(c[0], c[1], c[2]);
            else if (!has_inside || (has_outside && r < 92))
            begin
                // Push at least one coordinate past the volume in use.
                do
                    axis = $urandom_range(2, 0);
                while (dim_eff[axis] >= VOL_DIM);
                for (int a = 0; a < 3; a++)
                    c[a] = $urandom_range(VOL_DIM - 1, 0);
                c[axis] = $urandom_range(VOL_DIM - 1, dim_eff[axis]);
                if ($urandom_range(1, 0) == 0)
                    write_voxel(c[0], c[1], c[2]);
                else
                    send_word(CMD_QUERY, c[0], c[1], c[2], 1'($urandom_range(1, 0)),
                              1'($urandom_range(1, 0)), LABEL_W'($urandom_range(255, 0)),
                              1'b0, '0);
            end
            else
                probe_voxel($urandom_range(dim_eff[0] - 1, 0),
                            $urandom_range(dim_eff[1] - 1, 0),
                            $urandom_range(dim_eff[2] - 1, 0));
        end
    endtask

    // Result side: random stalls, mostly short, a few long.
    initial
    begin
        stall_left       = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_bus.ready = 1'b0;
                stall_left--;
            end
            else if (sink_eager || $urandom_range(99, 0) < 70)
                result_bus.ready = 1'b1;
            else
            begin
                result_bus.ready = 1'b0;
                stall_left = ($urandom_range(99, 0) < 90) ? $urandom_range(3, 0)
                                                           : $urandom_range(50, 15);
            end
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            if (pending_contacts.size() == 0)
            begin
                if (mismatches < MAX_SHOWN)
                    $display("unexpected result word: touching=%0b branch_out=%0b",
                             result_bus.touching, result_bus.branch_out);
                mismatches++;
            end
            else
            begin
                expected_contact = pending_contacts.pop_front();
                if (result_bus.touching !== expected_contact.touching ||
                    result_bus.branch_out !== expected_contact.branch_out)
                begin
                    if (mismatches < MAX_SHOWN)
                        $display("mismatch: expected touching=%0b branch_out=%0b, got %0b %0b",
                                 expected_contact.touching, expected_contact.branch_out,
                                 result_bus.touching, result_bus.branch_out);
                    mismatches++;
                end
            end
        end
    end

    // Reset, directed table, random phases, drain and verdict.
    initial
    begin
        rst_n                    = 1'b0;
        item_bus.valid           = 1'b0;
        item_bus.command         = CMD_WRITE;
        item_bus.coord_x         = '0;
        item_bus.coord_y         = '0;
        item_bus.coord_z         = '0;
        item_bus.initial_bit     = 1'b0;
        item_bus.reduced_bit     = 1'b0;
        item_bus.component_label = '0;
        cfg_bus.valid            = 1'b0;
        cfg_bus.index            = REG_COLS;
        cfg_bus.data             = '0;
        mismatches               = 0;
        words_sent               = 0;
        no_gaps                  = 1'b0;
        sink_eager               = 1'b0;
        branch_pct               = 30;
        for (int a = 0; a < 3; a++)
        begin
            dim_eff[a] = VOL_DIM;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].command, directed_rows[i].x, directed_rows[i].y,
                      directed_rows[i].z, directed_rows[i].initial_bit,
                      directed_rows[i].reduced_bit, directed_rows[i].label,
                      directed_rows[i].checked,
                      {directed_rows[i].touching, directed_rows[i].branch_out});

        // Sizes from a single voxel to oversized and empty axes.
        run_phase(4, 4, 4, 90);
        run_phase(1, 1, 1, 30);
        run_phase(0, 5, 3, 25);
        run_phase(127, 2, 64, 80);
        run_phase(3, 7, 2, 80);
        run_phase(64, 64, 64, 90);
        run_phase(64, 1, 127, 60);
        run_phase($urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(8, 1), 60);
        run_phase($urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(8, 1), 60);
        run_phase($urandom_range(127, 0), $urandom_range(127, 0), $urandom_range(127, 0), 60);

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_contacts.size() == 0)
            $display("skeleton_branch_contact_3d_unit_test: clean");
        else
            $display("skeleton_branch_contact_3d_unit_test: errors");
        $finish;
    end

endmodule

// ===== skeleton_branch_contact_3d_unit.f =====
+incdir+rtl
rtl/skbc_pkg.sv
rtl/skbc_item_if.sv
rtl/skbc_result_if.sv
rtl/skbc_cfg_if.sv
rtl/skbc_ctrl.sv
rtl/skbc_datapath.sv
rtl/skeleton_branch_contact_3d_unit.sv
rtl/skbc_checker.sv
tb/skeleton_branch_contact_3d_unit_test.sv
